FILE: rtl/msb_pkg.sv
// Shared types and codes for the multi-stack shared buffer.
// Used by the top level and by the port checker; no dependencies.

package msb_pkg;

    typedef logic [1:0]  status_t;
    typedef logic [31:0] word_t;

    localparam int STACK_NUMBER_W = 3;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // word returned by a pop on an empty stack
    localparam word_t EMPTY_WORD = '1;

endpackage

FILE: rtl/msb_link_mem.sv
// Slot link store: synchronous memory with registered read data.
// A fill count stands in for the reset pattern (slot i links to i+1),
// so no clearing pass is needed. Depends on nothing.

module msb_link_mem #(
    parameter int NUM_SLOTS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [$clog2(NUM_SLOTS+1)-1:0]   rd_addr,
    output logic [$clog2(NUM_SLOTS+1)-1:0]   rd_data,
    input  logic                             wr_en,
    input  logic [$clog2(NUM_SLOTS+1)-1:0]   wr_addr,
    input  logic [$clog2(NUM_SLOTS+1)-1:0]   wr_data
);

    localparam int PW = $clog2(NUM_SLOTS + 1);
    localparam int AW = $clog2(NUM_SLOTS);

    logic [PW-1:0] links_mem [NUM_SLOTS];
    logic [PW-1:0] mem_q_reg;
    logic [PW-1:0] seq_reg;
    logic          fresh_reg;
    logic [PW-1:0] fill_reg;
    logic [PW-1:0] fill_next;

    // slots are first written in index order, so everything at or above
    // the fill count still holds its reset link
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && (wr_addr == fill_reg))
        begin
            fill_next = fill_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            links_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= links_mem[rd_addr[AW-1:0]];
            seq_reg   <= rd_addr + PW'(1);
            fresh_reg <= (rd_addr >= fill_reg);
        end
    end

    assign rd_data = fresh_reg ? seq_reg : mem_q_reg;

endmodule

FILE: rtl/multi_stack_shared_buffer.sv
// Multi-stack shared buffer: LIFO stacks threaded through one slot store.
// Timing: done is registered and rises after the head state for a push or an
// empty pop, after the further pop state for a pop that returns a word (link/word read).
// A new word is taken only once the block is idle again, as the dependent memory
// reads set. The receiver cannot stall the one-cycle strobe.
// Reset: all stacks empty, free list holds every slot in order, no pass.

module multi_stack_shared_buffer #(
    parameter int NUM_STACKS = 8,
    parameter int NUM_SLOTS  = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic [msb_pkg::STACK_NUMBER_W-1:0]  stack_number,
    input  logic signed [31:0]                  push_value,
    output logic                                done,
    output msb_pkg::status_t                    status,
    output logic signed [31:0]                  pop_value
);

    localparam int PW = $clog2(NUM_SLOTS + 1);
    localparam int AW = $clog2(NUM_SLOTS);
    localparam int HW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [PW-1:0] NULL_PTR = PW'(NUM_SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HEAD = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0]                         state_reg, state_next;
    logic                               op_reg;
    logic [msb_pkg::STACK_NUMBER_W-1:0] sn_reg;
    msb_pkg::word_t                     val_reg;
    logic [PW-1:0]                      free_head_reg, free_head_next;
    logic [PW-1:0]                      top_reg;

    logic [PW-1:0]         heads_mem [NUM_STACKS];
    logic [PW-1:0]         head_q_reg;
    logic                  head_ok_reg;
    logic [NUM_STACKS-1:0] head_valid_reg;

    msb_pkg::word_t        values_mem [NUM_SLOTS];
    msb_pkg::word_t        value_q_reg;

    logic                  done_reg;
    msb_pkg::status_t      status_reg;
    msb_pkg::word_t        pop_value_reg;

    logic                  accept;
    logic [HW-1:0]         in_idx;
    logic [HW-1:0]         cur_idx;
    logic                  out_of_range;
    logic [PW-1:0]         head_eff;

    logic                  link_rd_en, link_wr_en;
    logic [PW-1:0]         link_rd_addr, link_rd_data;
    logic [PW-1:0]         link_wr_addr, link_wr_data;

    logic                  head_wr_en;
    logic [PW-1:0]         head_wr_data;
    logic                  value_wr_en, value_rd_en;

    logic                  res_en;
    msb_pkg::status_t      res_status;
    msb_pkg::word_t        res_word;

    assign accept       = start && !busy;
    assign busy         = (state_reg != S_IDLE);
    assign in_idx       = HW'(stack_number);
    assign cur_idx      = HW'(sn_reg);
    assign out_of_range = (32'(sn_reg) >= 32'(NUM_STACKS));
    assign head_eff     = head_ok_reg ? head_q_reg : NULL_PTR;

    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        link_rd_en     = 1'b0;
        link_rd_addr   = free_head_reg;
        link_wr_en     = 1'b0;
        link_wr_addr   = free_head_reg;
        link_wr_data   = head_eff;
        head_wr_en     = 1'b0;
        head_wr_data   = free_head_reg;
        value_wr_en    = 1'b0;
        value_rd_en    = 1'b0;
        res_en         = 1'b0;
        res_status     = msb_pkg::ST_DONE;
        res_word       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // fetch the free-list successor alongside the head
                    link_rd_en = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (op_reg == msb_pkg::OP_PUSH)
                begin
                    res_en     = 1'b1;
                    state_next = S_IDLE;
                    if (out_of_range || (free_head_reg == NULL_PTR))
                    begin
                        res_status = msb_pkg::ST_FULL;
                    end
                    else
                    begin
                        link_wr_en     = 1'b1;
                        head_wr_en     = 1'b1;
                        value_wr_en    = 1'b1;
                        free_head_next = link_rd_data;
                    end
                end
                else
                begin
                    if (out_of_range || (head_eff >= NULL_PTR))
                    begin
                        res_en     = 1'b1;
                        res_status = msb_pkg::ST_EMPTY;
                        res_word   = msb_pkg::EMPTY_WORD;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        link_rd_en   = 1'b1;
                        link_rd_addr = head_eff;
                        value_rd_en  = 1'b1;
                        state_next   = S_POP;
                    end
                end
            end
            S_POP:
            begin
                // unlink the top slot and return it to the free list
                link_wr_en     = 1'b1;
                link_wr_addr   = top_reg;
                link_wr_data   = free_head_reg;
                head_wr_en     = 1'b1;
                head_wr_data   = link_rd_data;
                free_head_next = top_reg;
                res_en         = 1'b1;
                res_word       = value_q_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_head_reg  <= '0;
            head_valid_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            done_reg      <= res_en;
            if (head_wr_en)
            begin
                head_valid_reg[cur_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= operation;
            sn_reg      <= stack_number;
            val_reg     <= push_value;
            head_q_reg  <= heads_mem[in_idx];
            head_ok_reg <= head_valid_reg[in_idx];
        end
        if (head_wr_en)
        begin
            heads_mem[cur_idx] <= head_wr_data;
        end
        if (value_wr_en)
        begin
            values_mem[free_head_reg[AW-1:0]] <= val_reg;
        end
        if (value_rd_en)
        begin
            value_q_reg <= values_mem[head_eff[AW-1:0]];
            top_reg     <= head_eff;
        end
        if (res_en)
        begin
            status_reg    <= res_status;
            pop_value_reg <= res_word;
        end
    end

    msb_link_mem #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_links (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data)
    );

    assign done      = done_reg;
    assign status    = status_reg;
    assign pop_value = pop_value_reg;

endmodule

FILE: rtl/msb_checker.sv
// Port-level checks for the multi-stack shared buffer, bound to the top.
// Depends on msb_pkg for status codes.

module msb_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input msb_pkg::status_t       status,
    input logic signed [31:0]     pop_value
);

    // an accepted word always occupies the block for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // a result is only strobed once the block is free again
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == msb_pkg::ST_DONE || status == msb_pkg::ST_FULL ||
                  status == msb_pkg::ST_EMPTY))
        else $error("undefined status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == msb_pkg::ST_EMPTY) |-> (pop_value == msb_pkg::EMPTY_WORD))
        else $error("empty pop did not return all ones");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == msb_pkg::ST_FULL) |-> (pop_value == '0))
        else $error("refused push returned a nonzero word");

endmodule

bind multi_stack_shared_buffer msb_checker u_msb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .pop_value (pop_value)
);

FILE: sim/testbench.sv
// Testbench for the multi-stack shared buffer: directed and random push/pop words.
// Checks every result strobe against a shadow copy of the stacks and free list.
// Depends on rtl/msb_pkg.sv and rtl/multi_stack_shared_buffer.sv.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACKS = 8;
    localparam int SLOTS  = 256;
    localparam int NIL    = SLOTS;

    typedef struct packed {
        msb_pkg::status_t status;
        msb_pkg::word_t   word;
    } answer_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               operation = msb_pkg::OP_PUSH;
    logic [msb_pkg::STACK_NUMBER_W-1:0] stack_number = '0;
    logic signed [31:0]                 push_value = '0;
    logic                               busy;
    logic                               done;
    msb_pkg::status_t                   status;
    logic signed [31:0]                 pop_value;

    // shadow of the block's store
    msb_pkg::word_t slot_word [SLOTS];
    int             slot_next [SLOTS];
    int             top_slot  [STACKS];
    int             free_slot;
    int             slots_used;

    answer_t answers_due[$];

    int errors;
    int items_sent;
    int pushes_done, pops_done, full_refusals, empty_refusals;
    bit steady;

    multi_stack_shared_buffer #(
        .NUM_STACKS(STACKS),
        .NUM_SLOTS (SLOTS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .stack_number(stack_number),
        .push_value  (push_value),
        .done        (done),
        .status      (status),
        .pop_value   (pop_value)
    );

    always #2 clk = ~clk;

    // Apply one word to the shadow store and give the answer it must produce.
    function automatic answer_t stack_op_answer(logic op, int sn, msb_pkg::word_t val);
        answer_t ans;
        int      slot;
        ans.status = msb_pkg::ST_DONE;
        ans.word   = '0;
        if (op == msb_pkg::OP_PUSH)
        begin
            if (sn >= STACKS || free_slot == NIL)
            begin
                ans.status = msb_pkg::ST_FULL;
                full_refusals++;
            end
            else
            begin
                slot            = free_slot;
                free_slot       = slot_next[slot];
                slot_word[slot] = val;
                slot_next[slot] = top_slot[sn];
                top_slot[sn]    = slot;
                slots_used++;
                pushes_done++;
            end
        end
        else
        begin
            if (sn >= STACKS || top_slot[sn] == NIL)
            begin
                ans.status = msb_pkg::ST_EMPTY;
                ans.word   = msb_pkg::EMPTY_WORD;
                empty_refusals++;
            end
            else
            begin
                slot            = top_slot[sn];
                top_slot[sn]    = slot_next[slot];
                slot_next[slot] = free_slot;
                free_slot       = slot;
                ans.word        = slot_word[slot];
                slots_used--;
                pops_done++;
            end
        end
        return ans;
    endfunction

    // Bias towards the corners of the signed range now and then.
    function automatic msb_pkg::word_t rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Hold the word until the block takes it, then idle for a while (or not).
    task automatic send_word(input logic op, input int sn, input msb_pkg::word_t val);
        int gap;
        int r;
        start        <= 1'b1;
        operation    <= op;
        stack_number <= sn[msb_pkg::STACK_NUMBER_W-1:0];
        push_value   <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        answers_due.push_back(stack_op_answer(op, sn, val));
        items_sent++;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic test_directed_corners();
        send_word(msb_pkg::OP_POP, 0, $urandom);            // empty stack
        send_word(msb_pkg::OP_POP, 7, $urandom);
        send_word(msb_pkg::OP_PUSH, 0, 32'h7FFF_FFFF);
        send_word(msb_pkg::OP_PUSH, 7, 32'h8000_0000);
        send_word(msb_pkg::OP_PUSH, 3, 32'h0000_0000);
        send_word(msb_pkg::OP_PUSH, 3, 32'hFFFF_FFFF);
        send_word(msb_pkg::OP_PUSH, 3, 32'hA5A5_5A5A);
        send_word(msb_pkg::OP_POP, 3, 32'hFFFF_FFFF);       // pushed value ignored on pop
        send_word(msb_pkg::OP_POP, 3, '0);
        send_word(msb_pkg::OP_POP, 3, $urandom);
        send_word(msb_pkg::OP_POP, 3, $urandom);            // now empty again
        send_word(msb_pkg::OP_PUSH, 1, 32'h1234_5678);
        send_word(msb_pkg::OP_PUSH, 2, 32'h8765_4321);
        send_word(msb_pkg::OP_POP, 1, $urandom);            // slot goes back to the free list
        send_word(msb_pkg::OP_PUSH, 1, 32'h5555_5555);      // and is reused here
        send_word(msb_pkg::OP_POP, 2, $urandom);
        send_word(msb_pkg::OP_POP, 1, $urandom);
        send_word(msb_pkg::OP_POP, 7, $urandom);
        send_word(msb_pkg::OP_POP, 0, $urandom);
        send_word(msb_pkg::OP_POP, 7, $urandom);
        send_word(msb_pkg::OP_POP, 4, $urandom);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            send_word(1'($urandom_range(0, 1)), $urandom_range(0, STACKS - 1), rand_word());
    endtask

    // Mostly pushes: run the store into full and keep knocking on it.
    task automatic test_fill_to_full();
        int n;
        int refused_before;
        n = 0;
        refused_before = full_refusals;
        while (full_refusals - refused_before < 10 && n < 450)
        begin
            steady = (n % 100) < 30;
            send_word(($urandom_range(0, 99) < 97) ? msb_pkg::OP_PUSH : msb_pkg::OP_POP,
                      $urandom_range(0, STACKS - 1), rand_word());
            n++;
        end
        steady = 1'b0;
    endtask

    // Mostly pops: empty every stack and hit empty stacks repeatedly.
    task automatic test_drain_to_empty();
        int n;
        int refused_before;
        n = 0;
        refused_before = empty_refusals;
        while ((slots_used != 0 || empty_refusals - refused_before < 12) && n < 450)
        begin
            steady = (n % 80) >= 60;
            send_word(($urandom_range(0, 99) < 97) ? msb_pkg::OP_POP : msb_pkg::OP_PUSH,
                      $urandom_range(0, STACKS - 1), rand_word());
            n++;
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_answers
        answer_t exp;
        if (rst_n && done === 1'b1)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result strobe with no word outstanding: status %0d pop_value %0d",
                       status, pop_value);
                errors++;
            end
            else
            begin
                exp = answers_due.pop_front();
                if (status !== exp.status)
                begin
                    $error("status: expected %0d, actual %0d", exp.status, status);
                    errors++;
                end
                if (pop_value !== exp.word)
                begin
                    $error("pop_value: expected %0d, actual %0d",
                           $signed(exp.word), pop_value);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int waited;
        errors = 0;
        items_sent = 0;
        steady = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_word[i] = '0;
            slot_next[i] = i + 1;
        end
        for (int s = 0; s < STACKS; s++)
            top_slot[s] = NIL;
        free_slot  = 0;
        slots_used = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_mix(40);
        test_fill_to_full();
        test_random_mix(20);
        test_drain_to_empty();
        test_random_mix(20);

        start <= 1'b0;
        waited = 0;
        while (answers_due.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (answers_due.size() != 0)
        begin
            $error("%0d results never arrived", answers_due.size());
            errors++;
        end

        $display("Sent %0d words: %0d pushes stored, %0d pops returned a word,",
                 items_sent, pushes_done, pops_done);
        $display("%0d pushes refused on a full store, %0d pops on an empty stack.",
                 full_refusals, empty_refusals);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/msb_pkg.sv
rtl/msb_link_mem.sv
rtl/multi_stack_shared_buffer.sv
rtl/msb_checker.sv
sim/testbench.sv
